>>> src/scanline_tint_desaturate_defines.svh
// ----------------------------------------------------------------------------
// Scanline tint desaturate assertion macros
// Shared concurrent assertion forms, clocked on i_clk with reset i_rst_n.
// ----------------------------------------------------------------------------
`ifndef SCANLINE_TINT_DESATURATE_DEFINES_SVH
`define SCANLINE_TINT_DESATURATE_DEFINES_SVH

// Checked only while the block is out of reset.
`define SCNTD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define SCNTD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

>>> src/scntd_pkg.sv
// ----------------------------------------------------------------------------
// Scanline tint desaturate package
// Word types, register indexes, reset values, step codes and the sine table.
// ----------------------------------------------------------------------------
package scntd_pkg;

    localparam int DEF_PHASE_BITS   = 16;
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int CFG_INDEX_W      = 2;
    localparam int CFG_DATA_W       = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_STEP = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BOOST      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DESAT      = 2'd2;

    localparam logic [15:0] RST_PHASE_STEP = 16'd1638;
    localparam logic [8:0]  RST_BOOST      = 9'd128;
    localparam logic [8:0]  RST_DESAT      = 9'd179;

    localparam logic [8:0] ONE_Q8    = 9'd256;
    localparam logic [8:0] HALF_Q8   = 9'd128;
    localparam logic [9:0] RECIP3    = 10'd683;
    localparam logic [7:0] PIX_MAX   = 8'd255;

    typedef struct packed {
        logic [7:0] blue_in;
        logic [7:0] green_in;
        logic [7:0] red_in;
        logic       row_end;
        logic       frame_end;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] blue_out;
        logic [7:0] green_out;
        logic [7:0] red_out;
        logic       row_end_out;
        logic       frame_end_out;
    } t_pix_out;

    typedef enum logic [3:0] {
        STEP_NONE,
        STEP_WS,
        STEP_MB,
        STEP_QB,
        STEP_MG,
        STEP_QG,
        STEP_MR,
        STEP_QR,
        STEP_K,
        STEP_BB
    } t_step;

    typedef struct packed {
        logic  load;
        t_step step;
        logic  emit;
    } t_dp_cmd;

    localparam logic [7:0] QUARTER_SINE [65] = '{
          8'd0,   8'd3,   8'd6,   8'd9,  8'd13,  8'd16,  8'd19,  8'd22,
         8'd25,  8'd28,  8'd31,  8'd34,  8'd37,  8'd40,  8'd43,  8'd46,
         8'd49,  8'd52,  8'd55,  8'd58,  8'd60,  8'd63,  8'd66,  8'd68,
         8'd71,  8'd74,  8'd76,  8'd79,  8'd81,  8'd84,  8'd86,  8'd88,
         8'd91,  8'd93,  8'd95,  8'd97,  8'd99, 8'd101, 8'd103, 8'd105,
        8'd106, 8'd108, 8'd110, 8'd111, 8'd113, 8'd114, 8'd116, 8'd117,
        8'd118, 8'd119, 8'd121, 8'd122, 8'd122, 8'd123, 8'd124, 8'd125,
        8'd126, 8'd126, 8'd127, 8'd127, 8'd127, 8'd128, 8'd128, 8'd128,
        8'd128
    };

    // Row coefficient 0.5 + sin/2 in Q1.8 for an angle on a 256-step circle.
    function automatic logic [8:0] sine_coef(input logic [7:0] angle);
        logic [6:0] h;
        logic [6:0] idx;
        logic [7:0] mag;
        begin
            h   = angle[6:0];
            idx = (h <= 7'd64) ? h : 7'(8'd128 - {1'b0, h});
            mag = QUARTER_SINE[idx];
            sine_coef = angle[7] ? 9'(HALF_Q8 - {1'b0, mag}) : 9'(HALF_Q8 + {1'b0, mag});
        end
    endfunction

endpackage

>>> src/scntd_ctrl.sv
// ----------------------------------------------------------------------------
// Scanline tint desaturate controller
// Sequences one pixel through the shared multiplier steps of the datapath.
// ----------------------------------------------------------------------------
`include "scanline_tint_desaturate_defines.svh"

module scntd_ctrl
    import scntd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [10:0] {
        ST_IDLE = 11'b00000000001,
        ST_WS   = 11'b00000000010,
        ST_MB   = 11'b00000000100,
        ST_QB   = 11'b00000001000,
        ST_MG   = 11'b00000010000,
        ST_QG   = 11'b00000100000,
        ST_MR   = 11'b00001000000,
        ST_QR   = 11'b00010000000,
        ST_K    = 11'b00100000000,
        ST_BB   = 11'b01000000000,
        ST_SPARE = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_acc;
    logic   out_room;

    assign in_acc     = i_in_valid && (r_state == ST_IDLE);
    assign out_room   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.load  = in_acc;
        o_cmd.step  = STEP_NONE;
        o_cmd.emit  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_WS;
                end
            end
            ST_WS: begin
                o_cmd.step = STEP_WS;
                n_state    = ST_MB;
            end
            ST_MB: begin
                o_cmd.step = STEP_MB;
                n_state    = ST_QB;
            end
            ST_QB: begin
                o_cmd.step = STEP_QB;
                n_state    = ST_MG;
            end
            ST_MG: begin
                o_cmd.step = STEP_MG;
                n_state    = ST_QG;
            end
            ST_QG: begin
                o_cmd.step = STEP_QG;
                n_state    = ST_MR;
            end
            ST_MR: begin
                o_cmd.step = STEP_MR;
                n_state    = ST_QR;
            end
            ST_QR: begin
                o_cmd.step = STEP_QR;
                n_state    = ST_K;
            end
            ST_K: begin
                o_cmd.step = STEP_K;
                n_state    = ST_BB;
            end
            ST_BB: begin
                o_cmd.step = STEP_BB;
                if (out_room) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `SCNTD_ASSERT(a_accept_starts, (i_in_valid && o_in_ready) |=> (r_state == ST_WS),
        "accepted word did not start the sequence")
    `SCNTD_ASSERT(a_finish_emits,
        (r_state == ST_BB && out_room) |=> (r_out_valid && r_state == ST_IDLE),
        "finished word was not delivered")
    `SCNTD_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (r_state == ST_IDLE && !r_out_valid),
        "reset did not clear the controller")

endmodule

>>> src/scntd_datapath.sv
// ----------------------------------------------------------------------------
// Scanline tint desaturate datapath
// Holds the registers, row phase, one shared multiplier and the output word.
// ----------------------------------------------------------------------------
module scntd_datapath
    import scntd_pkg::*;
#(
    parameter int PHASE_BITS = DEF_PHASE_BITS
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    input  t_pix_in                i_in_data,
    input  logic                   i_cfg_valid,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_pix_out               o_out_data
);

    logic [15:0]           r_phase_step;
    logic [8:0]            r_boost;
    logic [8:0]            r_desat;
    logic [PHASE_BITS-1:0] r_row_phase;

    logic [7:0]  r_b, r_g, r_r;
    logic        r_re, r_fe;
    logic [9:0]  r_sum;
    logic [8:0]  r_w;
    logic [8:0]  r_inten;
    logic [9:0]  r_wc;
    logic [8:0]  r_coef;
    logic [17:0] r_ws;
    logic [17:0] r_acc;
    logic [7:0]  r_db, r_dg, r_dr;
    logic [16:0] r_k;
    t_pix_out    r_out;

    logic [8:0]             w_sat;
    logic [8:0]             i_sat;
    logic [8:0]             inv_w;
    logic [PHASE_BITS+15:0] step_wide;
    logic [PHASE_BITS-1:0]  step_pb;
    logic [16:0]            mul_a;
    logic [9:0]             mul_b;
    logic [26:0]            prod;
    logic [8:0]             bb_sum;
    logic [7:0]             bb;

    assign w_sat     = r_desat[8] ? ONE_Q8 : r_desat;
    assign i_sat     = r_boost[8] ? ONE_Q8 : r_boost;
    assign inv_w     = 9'(ONE_Q8 - w_sat);
    assign step_wide = {{PHASE_BITS{1'b0}}, r_phase_step};
    assign step_pb   = step_wide[PHASE_BITS-1:0];

    always_comb begin
        unique case (i_cmd.step)
            STEP_WS: begin
                mul_a = 17'(r_w);
                mul_b = r_sum;
            end
            STEP_MB: begin
                mul_a = 17'(r_b);
                mul_b = r_wc;
            end
            STEP_MG: begin
                mul_a = 17'(r_g);
                mul_b = r_wc;
            end
            STEP_MR: begin
                mul_a = 17'(r_r);
                mul_b = r_wc;
            end
            STEP_QB, STEP_QG, STEP_QR: begin
                mul_a = 17'(r_acc[17:8]);
                mul_b = RECIP3;
            end
            STEP_K: begin
                mul_a = 17'(r_coef);
                mul_b = 10'(r_inten);
            end
            STEP_BB: begin
                mul_a = r_k;
                mul_b = 10'(PIX_MAX - r_db);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod   = 27'(mul_a) * 27'(mul_b);
    assign bb_sum = 9'(r_db) + 9'(prod[23:16]);
    assign bb     = bb_sum[8] ? PIX_MAX : bb_sum[7:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= RST_PHASE_STEP;
            r_boost      <= RST_BOOST;
            r_desat      <= RST_DESAT;
            r_row_phase  <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_PHASE_STEP: r_phase_step <= i_cfg_data;
                    CFG_BOOST:      r_boost      <= i_cfg_data[8:0];
                    CFG_DESAT:      r_desat      <= i_cfg_data[8:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.load) begin
                if (i_in_data.frame_end) begin
                    r_row_phase <= '0;
                end else if (i_in_data.row_end) begin
                    r_row_phase <= r_row_phase + step_pb;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_b     <= i_in_data.blue_in;
            r_g     <= i_in_data.green_in;
            r_r     <= i_in_data.red_in;
            r_re    <= i_in_data.row_end;
            r_fe    <= i_in_data.frame_end;
            r_sum   <= 10'(i_in_data.blue_in) + 10'(i_in_data.green_in)
                     + 10'(i_in_data.red_in);
            r_w     <= w_sat;
            r_inten <= i_sat;
            r_wc    <= 10'({inv_w, 1'b0}) + 10'(inv_w);
            r_coef  <= sine_coef(r_row_phase[PHASE_BITS-1 -: 8]);
        end
        unique case (i_cmd.step)
            STEP_WS:                   r_ws  <= prod[17:0];
            STEP_MB, STEP_MG, STEP_MR: r_acc <= prod[17:0] + r_ws;
            STEP_QB:                   r_db  <= prod[18:11];
            STEP_QG:                   r_dg  <= prod[18:11];
            STEP_QR:                   r_dr  <= prod[18:11];
            STEP_K:                    r_k   <= prod[16:0];
            default: begin
            end
        endcase
        if (i_cmd.emit) begin
            r_out.blue_out      <= bb;
            r_out.green_out     <= r_dg;
            r_out.red_out       <= r_dr;
            r_out.row_end_out   <= r_re;
            r_out.frame_end_out <= r_fe;
        end
    end

    assign o_out_data = r_out;

endmodule

>>> src/scanline_tint_desaturate.sv
// ----------------------------------------------------------------------------
// Scanline tint desaturate
// Desaturates BGR pixels toward their mean and adds a row-periodic blue tint.
//
//   Channel   Direction  Handshake                   Word
//   input     in         i_in_valid / o_in_ready     t_pix_in
//   output    out        o_out_valid / i_out_ready   t_pix_out
//   config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// All products of a pixel go through one shared multiplier in nine steps,
// one step per cycle while the output is not stalled.
// The controller is idle again once the result is registered, and a new pixel
// is taken only while it is idle, so one pixel is finished before the next.
// The output register holds one finished word, so the next pixel is taken
// while a result waits; a stalled output halts the final step only.
// Reset is synchronous and restores the register defaults and row phase zero.
// Configuration writes are taken in every cycle.
// ----------------------------------------------------------------------------
module scanline_tint_desaturate
    import scntd_pkg::*;
#(
    parameter int PHASE_BITS = DEF_PHASE_BITS
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_pix_in                i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_pix_out               o_out_data,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_dp_cmd cmd;

    assign o_cfg_ready = 1'b1;

    scntd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    scntd_datapath #(
        .PHASE_BITS (PHASE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (o_out_data)
    );

endmodule

>>> dv/scanline_tint_desaturate_tb.sv
// ----------------------------------------------------------------------------
// Scanline tint desaturate testbench
// Drives pixel words through the block under random stalls on both channels.
// Each result word is checked field by field against its literal expected
// word or against an in-bench model of the desaturation, the sine-driven
// blue boost and the row phase accumulator. A short table of directed words
// and register writes opens the run. Random phases follow, each with its own
// register settings and framed pixel rows.
// ----------------------------------------------------------------------------
module scanline_tint_desaturate_tb
    import scntd_pkg::*;
();

    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 24;
    localparam int N_PHASES       = 8;
    localparam int PHASE_ITEMS    = 56;
    localparam int N_DIR          = 25;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    localparam bit [7:0] QSINE [65] = '{
          8'd0,   8'd3,   8'd6,   8'd9,  8'd13,  8'd16,  8'd19,  8'd22,
         8'd25,  8'd28,  8'd31,  8'd34,  8'd37,  8'd40,  8'd43,  8'd46,
         8'd49,  8'd52,  8'd55,  8'd58,  8'd60,  8'd63,  8'd66,  8'd68,
         8'd71,  8'd74,  8'd76,  8'd79,  8'd81,  8'd84,  8'd86,  8'd88,
         8'd91,  8'd93,  8'd95,  8'd97,  8'd99, 8'd101, 8'd103, 8'd105,
        8'd106, 8'd108, 8'd110, 8'd111, 8'd113, 8'd114, 8'd116, 8'd117,
        8'd118, 8'd119, 8'd121, 8'd122, 8'd122, 8'd123, 8'd124, 8'd125,
        8'd126, 8'd126, 8'd127, 8'd127, 8'd127, 8'd128, 8'd128, 8'd128,
        8'd128
    };

    typedef enum bit {ROW_PIX, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind                kind;
        logic [CFG_INDEX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]    data;
        t_pix_in                  pix;
        bit                       lit;
        t_pix_out                 want;
    } t_dir_row;

    localparam t_dir_row DIR_TAB [N_DIR] = '{
        '{ROW_PIX, '0, '0, {8'd0, 8'd0, 8'd0, 1'b0, 1'b0}, 1'b1,
          {8'd63, 8'd0, 8'd0, 1'b0, 1'b0}},
        '{ROW_PIX, '0, '0, {8'd255, 8'd255, 8'd255, 1'b0, 1'b0}, 1'b1,
          {8'd255, 8'd255, 8'd255, 1'b0, 1'b0}},
        '{ROW_PIX, '0, '0, {8'd255, 8'd0, 8'd0, 1'b1, 1'b0}, 1'b0, '0},
        '{ROW_PIX, '0, '0, {8'd0, 8'd255, 8'd0, 1'b0, 1'b0}, 1'b0, '0},
        '{ROW_PIX, '0, '0, {8'd0, 8'd0, 8'd255, 1'b1, 1'b1}, 1'b0, '0},
        '{ROW_PIX, '0, '0, {8'd0, 8'd0, 8'd0, 1'b0, 1'b1}, 1'b0, '0},
        '{ROW_CFG, CFG_DESAT, 16'd0, '0, 1'b0, '0},
        '{ROW_CFG, CFG_BOOST, 16'd0, '0, 1'b0, '0},
        '{ROW_PIX, '0, '0, {8'd10, 8'd200, 8'd77, 1'b0, 1'b0}, 1'b1,
          {8'd10, 8'd200, 8'd77, 1'b0, 1'b0}},
        '{ROW_CFG, CFG_DESAT, 16'd256, '0, 1'b0, '0},
        '{ROW_PIX, '0, '0, {8'd0, 8'd0, 8'd255, 1'b0, 1'b0}, 1'b1,
          {8'd85, 8'd85, 8'd85, 1'b0, 1'b0}},
        '{ROW_CFG, CFG_DESAT, 16'hFFFF, '0, 1'b0, '0},
        '{ROW_PIX, '0, '0, {8'd255, 8'd0, 8'd0, 1'b0, 1'b0}, 1'b1,
          {8'd85, 8'd85, 8'd85, 1'b0, 1'b0}},
        '{ROW_CFG, CFG_BOOST, 16'hFFFF, '0, 1'b0, '0},
        '{ROW_CFG, CFG_PHASE_STEP, 16'h4000, '0, 1'b0, '0},
        '{ROW_PIX, '0, '0, {8'd0, 8'd0, 8'd0, 1'b1, 1'b0}, 1'b1,
          {8'd127, 8'd0, 8'd0, 1'b1, 1'b0}},
        '{ROW_PIX, '0, '0, {8'd0, 8'd0, 8'd0, 1'b1, 1'b0}, 1'b1,
          {8'd255, 8'd0, 8'd0, 1'b1, 1'b0}},
        '{ROW_PIX, '0, '0, {8'd0, 8'd0, 8'd0, 1'b1, 1'b0}, 1'b1,
          {8'd127, 8'd0, 8'd0, 1'b1, 1'b0}},
        '{ROW_PIX, '0, '0, {8'd0, 8'd0, 8'd0, 1'b1, 1'b0}, 1'b1,
          {8'd0, 8'd0, 8'd0, 1'b1, 1'b0}},
        '{ROW_PIX, '0, '0, {8'd0, 8'd0, 8'd0, 1'b0, 1'b0}, 1'b1,
          {8'd127, 8'd0, 8'd0, 1'b0, 1'b0}},
        '{ROW_CFG, CFG_UNUSED, 16'hFFFF, '0, 1'b0, '0},
        '{ROW_PIX, '0, '0, {8'd200, 8'd100, 8'd50, 1'b1, 1'b0}, 1'b0, '0},
        '{ROW_CFG, CFG_PHASE_STEP, 16'hFFFF, '0, 1'b0, '0},
        '{ROW_PIX, '0, '0, {8'd37, 8'd250, 8'd128, 1'b1, 1'b0}, 1'b0, '0},
        '{ROW_PIX, '0, '0, {8'd255, 8'd255, 8'd0, 1'b1, 1'b0}, 1'b0, '0}
    };

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    t_pix_in                i_in_data;
    logic                   o_out_valid;
    logic                   i_out_ready;
    t_pix_out               o_out_data;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    logic [15:0] step_reg;
    logic [8:0]  boost_reg;
    logic [8:0]  desat_reg;
    logic [15:0] line_phase;
    t_pix_out    graded_q [$];
    int          err_cnt;
    bit          allow_idle;
    bit          want_long_hold;

    scanline_tint_desaturate dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_pix_out grade_pixel(input t_pix_in px, input logic [15:0] ph);
        int unsigned w;
        int unsigned inten;
        int unsigned s;
        int unsigned db;
        int unsigned dg;
        int unsigned dr;
        int unsigned mag;
        int unsigned c;
        int unsigned bb;
        logic [7:0]  ang;
        logic [6:0]  h;
        t_pix_out    res;
        w     = (desat_reg > 9'd256) ? 256 : desat_reg;
        inten = (boost_reg > 9'd256) ? 256 : boost_reg;
        s     = px.blue_in + px.green_in + px.red_in;
        db    = ((256 - w) * 3 * px.blue_in + w * s) / 768;
        dg    = ((256 - w) * 3 * px.green_in + w * s) / 768;
        dr    = ((256 - w) * 3 * px.red_in + w * s) / 768;
        ang   = ph[15:8];
        h     = ang[6:0];
        mag   = (h <= 7'd64) ? QSINE[h] : QSINE[128 - int'(h)];
        c     = ang[7] ? 128 - mag : 128 + mag;
        bb    = db + ((inten * c * (255 - db)) >> 16);
        if (bb > 255) begin
            bb = 255;
        end
        res.blue_out      = 8'(bb);
        res.green_out     = 8'(dg);
        res.red_out       = 8'(dr);
        res.row_end_out   = px.row_end;
        res.frame_end_out = px.frame_end;
        return res;
    endfunction

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_pixel(input t_pix_in px, input bit lit, input t_pix_out lit_want);
        int       gap;
        t_pix_out g;
        gap = (allow_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= px;
        do @(posedge i_clk); while (!o_in_ready);
        g = grade_pixel(px, line_phase);
        graded_q.push_back(lit ? lit_want : g);
        if (px.frame_end) begin
            line_phase = '0;
        end else if (px.row_end) begin
            line_phase = line_phase + step_reg;
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_in_valid <= 1'b0;
        while (graded_q.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_PHASE_STEP: step_reg = data;
            CFG_BOOST:      boost_reg = data[8:0];
            CFG_DESAT:      desat_reg = data[8:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic report_field(input string fname, input logic [7:0] want, input logic [7:0] got);
        err_cnt++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    endtask

    task automatic check_word(input t_pix_out got);
        t_pix_out want;
        if (graded_q.size() == 0) begin
            err_cnt++;
            $display("%0t: output word %h with nothing pending", $time, got);
        end else begin
            want = graded_q.pop_front();
            if (got.blue_out !== want.blue_out)
                report_field("blue_out", want.blue_out, got.blue_out);
            if (got.green_out !== want.green_out)
                report_field("green_out", want.green_out, got.green_out);
            if (got.red_out !== want.red_out)
                report_field("red_out", want.red_out, got.red_out);
            if (got.row_end_out !== want.row_end_out)
                report_field("row_end_out", 8'(want.row_end_out), 8'(got.row_end_out));
            if (got.frame_end_out !== want.frame_end_out)
                report_field("frame_end_out", 8'(want.frame_end_out),
                             8'(got.frame_end_out));
        end
    endtask

    initial begin : out_side
        int hold;
        hold = 0;
        i_out_ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                check_word(o_out_data);
            end
            if (want_long_hold) begin
                want_long_hold = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else if (hold > 0) begin
                hold--;
                if (hold == 0) begin
                    i_out_ready <= 1'b1;
                end
            end else if (allow_idle && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 9);
                i_out_ready <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        int          n_rows;
        int          n_cols;
        int          sent;
        logic [15:0] step_v;
        logic [15:0] boost_v;
        logic [15:0] desat_v;
        t_pix_in     px;

        err_cnt        = 0;
        allow_idle     = 1'b1;
        want_long_hold = 1'b0;
        step_reg       = RST_PHASE_STEP;
        boost_reg      = RST_BOOST;
        desat_reg      = RST_DESAT;
        line_phase     = '0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < N_DIR; k++) begin
            if (DIR_TAB[k].kind == ROW_CFG) begin
                write_reg(DIR_TAB[k].idx, DIR_TAB[k].data);
            end else begin
                push_pixel(DIR_TAB[k].pix, DIR_TAB[k].lit, DIR_TAB[k].want);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            allow_idle = (p != 3) && (p != N_PHASES - 1);
            case (p)
                0: begin
                    step_v = 16'h0000; boost_v = 16'd256; desat_v = 16'd0;
                end
                1: begin
                    step_v = 16'hFFFF; boost_v = 16'd0; desat_v = 16'd256;
                end
                2: begin
                    step_v = RST_PHASE_STEP; boost_v = 16'(RST_BOOST); desat_v = 16'(RST_DESAT);
                end
                default: begin
                    step_v  = 16'($urandom);
                    boost_v = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 256));
                    desat_v = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 256));
                end
            endcase
            write_reg(CFG_PHASE_STEP, step_v);
            write_reg(CFG_BOOST, boost_v);
            write_reg(CFG_DESAT, desat_v);
            if (p == 4) begin
                write_reg(CFG_UNUSED, 16'($urandom));
            end
            if (p == 2 || p == 5) begin
                want_long_hold = 1'b1;
            end
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                n_rows = $urandom_range(1, 5);
                for (int r = 0; r < n_rows; r++) begin
                    n_cols = $urandom_range(1, 10);
                    for (int col = 0; col < n_cols; col++) begin
                        px.blue_in  = rand_chan();
                        px.green_in = rand_chan();
                        px.red_in   = rand_chan();
                        if ($urandom_range(0, 9) == 0) begin
                            px.green_in = px.blue_in;
                            px.red_in   = px.blue_in;
                        end
                        px.row_end   = (col == n_cols - 1);
                        px.frame_end = (col == n_cols - 1) && (r == n_rows - 1);
                        if ($urandom_range(0, 9) == 0) begin
                            px.row_end   = 1'($urandom_range(0, 1));
                            px.frame_end = 1'($urandom_range(0, 1));
                        end
                        push_pixel(px, 1'b0, '0);
                        sent++;
                    end
                end
            end
        end

        i_in_valid <= 1'b0;
        allow_idle = 1'b0;
        while (graded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/scntd_pkg.sv
src/scntd_ctrl.sv
src/scntd_datapath.sv
src/scanline_tint_desaturate.sv
dv/scanline_tint_desaturate_tb.sv
